// ===== src/phash_pkg.sv =====
// shared types and constants for the eight-lane pearson hash
package phash_pkg;

	localparam int BYTE_W      = 8;
	localparam int TABLE_DEPTH = 256;
	localparam int MAX_LANES   = 8;
	localparam int HASH_W      = 64;
	localparam int MOD_W       = 32;
	localparam int STEP_W      = $clog2(HASH_W);

	localparam logic [MOD_W-1:0] CLAMP_RESET = MOD_W'(1024);

	// command codes carried in tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_KEY   = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic             busy;
		logic [MOD_W-1:0] remainder;
	} mod_status_t;

endpackage

// ===== src/phash_table.sv =====
// replicated substitution table, one synchronous copy per lane
module phash_table #(
	parameter int LANES = 8
) (
	input  logic            clk,
	input  logic            we,
	input  phash_pkg::byte_t waddr,
	input  phash_pkg::byte_t wdata,
	input  phash_pkg::byte_t raddr [LANES],
	output phash_pkg::byte_t rdata [LANES]
);
	import phash_pkg::*;

	for (genvar j = 0; j < LANES; j++) begin : g_copy
		byte_t mem [TABLE_DEPTH];

		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata[j] <= mem[raddr[j]];
		end
	end

endmodule

// ===== src/phash_mod.sv =====
// bit-serial 64-by-32 remainder unit, one dividend bit per cycle
module phash_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [phash_pkg::HASH_W-1:0] dividend,
	input  logic [phash_pkg::MOD_W-1:0]  modulus,
	output phash_pkg::mod_status_t      status
);
	import phash_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [MOD_W-1:0]  rem_q;
	logic [MOD_W-1:0]  mod_q;
	logic [MOD_W:0]    trial;
	logic [MOD_W:0]    diff;

	assign trial = {rem_q, dvd_q[HASH_W-1]};
	assign diff  = trial - {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (cnt_q == STEP_W'(HASH_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			mod_q <= modulus;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			// trial stays below twice the modulus, so one subtract settles it
			rem_q <= diff[MOD_W] ? trial[MOD_W-1:0] : diff[MOD_W-1:0];
		end
	end

	// a zero modulus gives zero
	assign status.busy      = busy_q;
	assign status.remainder = (mod_q == '0) ? '0 : rem_q;

endmodule

// ===== src/pearson_hash_64.sv =====
// eight-lane pearson hash top level: control, lane registers, output register
//
// channel   dir  tdata                                  tuser / tlast
// s_axis    in   [7:0] table_index, [15:8] byte_value   tuser: command, tlast: last_byte
// m_axis    out  [31:0] hash_value                      -
// cfg       in   cfg_wdata: clamp_modulus               cfg_we strobe
//
// a table write is taken in idle; a key byte passes a table read and a lane update
// the final key byte then passes the serial remainder unit and the load of the output
// register; ready stays low until the result is in the output register
// reset clears the lanes, marks key start and sets clamp_modulus to 1024
// the table is undefined until written; the input stalls while a result waits for the output register
module pearson_hash_64 #(
	parameter int LANES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] table_index, [15:8] byte_value
	input  logic        s_axis_tuser,   // [0] command
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] hash_value
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import phash_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [MOD_W-1:0]  clamp_q;
	byte_t             lane_q [LANES];
	logic              key_start_q;
	logic              last_s1;
	logic              m_valid_q;
	logic [MOD_W-1:0]  m_data_q;

	logic              in_xfer;
	logic              key_xfer;
	logic              tbl_we;
	byte_t             tbl_idx;
	byte_t             in_byte;
	byte_t             raddr [LANES];
	byte_t             rdata [LANES];
	logic [HASH_W-1:0] word;
	logic              mod_start;
	logic              out_load;
	mod_status_t       mod_st;

	assign tbl_idx  = s_axis_tdata[BYTE_W-1:0];
	assign in_byte  = s_axis_tdata[2*BYTE_W-1:BYTE_W];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign key_xfer = in_xfer && (s_axis_tuser == CMD_KEY);
	assign tbl_we   = in_xfer && (s_axis_tuser == CMD_WRITE);

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			raddr[j] = key_start_q ? byte_t'(in_byte + byte_t'(j)) : (lane_q[j] ^ in_byte);
		end
	end

	// hash word from the fresh table data; lanes past LANES stay zero
	always_comb begin
		word = '0;
		for (int j = 0; j < LANES; j++) begin
			word[BYTE_W*j +: BYTE_W] = rdata[j];
		end
	end

	phash_table #(.LANES(LANES)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_idx),
		.wdata (in_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	phash_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (word),
		.modulus  (clamp_q),
		.status   (mod_st)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (key_xfer) begin
					state_nxt = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_nxt = last_s1 ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mod_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_LOOKUP: mod_start = last_s1;
			ST_DIV:    out_load = !mod_st.busy && (!m_valid_q || m_axis_tready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clamp_q     <= CLAMP_RESET;
			key_start_q <= 1'b1;
			last_s1     <= 1'b0;
			m_valid_q   <= 1'b0;
			for (int j = 0; j < LANES; j++) begin
				lane_q[j] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				clamp_q <= cfg_wdata;
			end
			if (key_xfer) begin
				last_s1 <= s_axis_tlast;
			end
			if (state_q == ST_LOOKUP) begin
				key_start_q <= last_s1;
				for (int j = 0; j < LANES; j++) begin
					lane_q[j] <= rdata[j];
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= mod_st.remainder;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule
